FILE: design/kuf_pkg.sv
package kuf_pkg;

    localparam int NODES   = 1024;
    localparam int IDX_W   = $clog2(NODES);
    localparam int NODE_W  = 10;
    localparam int CNT_W   = 11;
    localparam int W_W     = 16;
    localparam int COST_W  = 26;
    localparam int EDGE_W  = 10;
    localparam int RANK_W  = 4;

    localparam logic [CNT_W-1:0]  NODE_COUNT_RST = 11'd1024;
    localparam logic [RANK_W-1:0] RANK_MAX       = 4'd15;
    localparam logic [COST_W-1:0] COST_MAX       = {COST_W{1'b1}};
    localparam logic [EDGE_W-1:0] EDGES_MAX      = {EDGE_W{1'b1}};

    localparam logic ACT_CLEAR = 1'b0;
    localparam logic ACT_EDGE  = 1'b1;

    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_SAME_SET = 2'd1;
    localparam logic [1:0] ST_BAD_NODE = 2'd2;
    localparam logic [1:0] ST_CLEARED  = 2'd3;

    typedef struct packed {
        logic              action;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [W_W-1:0]    weight;
    } t_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [COST_W-1:0] total_cost;
        logic [EDGE_W-1:0] tree_edges;
    } t_result;

    typedef struct packed {
        logic [IDX_W-1:0]  parent;
        logic [RANK_W-1:0] rank;
    } t_entry;

endpackage

FILE: design/kruskal_union_find_edge_filter.sv
// kruskal edge filter: disjoint-set forest with union by rank and full path
// compression, held in one synchronous memory of {parent, rank} entries.
// input: a word on i_item is taken at a clock edge where start is high and
// busy is low. action clear resets every node to a singleton and zeroes the
// totals; action edge offers node_a-node_b with its weight.
// output: exactly one result word per input word, shown on o_result for one
// cycle with o_done high; the receiver cannot stall it.
// config: i_cfg_we writes node_count from i_cfg_data. the user must do
// so only while idle; the block itself does not enforce it.
// timing: a bad node index is answered in the cycle after it is taken,
// without leaving idle. for an edge, each find and each compression pass
// makes one memory read per tree level, the depth of each endpoint being
// at most log2(NODES) with union by rank. after an accepted edge busy
// stays high while the union writes one or two entries. a clear sweeps
// the memory one entry per cycle.
// reset: synchronous, active low; after reset the block runs the same
// clear sweep with busy high and no result, node_count becomes 1024.
module kruskal_union_find_edge_filter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  kuf_pkg::t_item    i_item,
    input  logic              i_cfg_we,
    input  logic [10:0]       i_cfg_data,
    output logic              o_done,
    output kuf_pkg::t_result  o_result
);
    import kuf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_FA    = 3'd2;
    localparam logic [2:0] S_CA    = 3'd3;
    localparam logic [2:0] S_FB    = 3'd4;
    localparam logic [2:0] S_CB    = 3'd5;
    localparam logic [2:0] S_LINK  = 3'd6;
    localparam logic [2:0] S_RANK  = 3'd7;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

    t_entry r_mem [NODES];
    t_entry r_q;

    logic [2:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_cnt, n_cnt;
    logic              r_emit_clr, n_emit_clr;
    logic [IDX_W-1:0]  r_cur, n_cur;
    logic [IDX_W-1:0]  r_a, n_a;
    logic [IDX_W-1:0]  r_b, n_b;
    logic [IDX_W-1:0]  r_ra, n_ra;
    logic [IDX_W-1:0]  r_rb, n_rb;
    logic [RANK_W-1:0] r_rank_a, n_rank_a;
    logic [RANK_W-1:0] r_rank_b, n_rank_b;
    logic [W_W-1:0]    r_w, n_w;
    logic [COST_W-1:0] r_cost, n_cost;
    logic [EDGE_W-1:0] r_edges, n_edges;
    logic [CNT_W-1:0]  r_node_count;
    logic              r_done, n_done;
    t_result           r_result, n_result;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_data;
    logic [COST_W:0]   cost_add;
    logic              bad_idx;

    assign cost_add = {1'b0, r_cost} + (COST_W+1)'(r_w);

    assign bad_idx = ({1'b0, i_item.node_a} >= r_node_count)
                  || ({1'b0, i_item.node_b} >= r_node_count)
                  || (32'(i_item.node_a) >= NODES)
                  || (32'(i_item.node_b) >= NODES);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_emit_clr = r_emit_clr;
        n_cur      = r_cur;
        n_a        = r_a;
        n_b        = r_b;
        n_ra       = r_ra;
        n_rb       = r_rb;
        n_rank_a   = r_rank_a;
        n_rank_b   = r_rank_b;
        n_w        = r_w;
        n_cost     = r_cost;
        n_edges    = r_edges;
        n_done     = 1'b0;
        n_result   = r_result;
        rd_en      = 1'b0;
        rd_addr    = r_cur;
        wr_en      = 1'b0;
        wr_addr    = r_cur;
        wr_data    = '{parent: r_ra, rank: r_q.rank};

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_item.action == ACT_CLEAR) begin
                        n_state    = S_CLEAR;
                        n_cnt      = '0;
                        n_emit_clr = 1'b1;
                        n_cost     = '0;
                        n_edges    = '0;
                    end else if (bad_idx) begin
                        n_done   = 1'b1;
                        n_result = '{status: ST_BAD_NODE, total_cost: r_cost,
                                     tree_edges: r_edges};
                    end else begin
                        n_a     = IDX_W'(i_item.node_a);
                        n_b     = IDX_W'(i_item.node_b);
                        n_w     = i_item.weight;
                        n_cur   = IDX_W'(i_item.node_a);
                        rd_en   = 1'b1;
                        rd_addr = IDX_W'(i_item.node_a);
                        n_state = S_FA;
                    end
                end
            end
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt;
                wr_data = '{parent: r_cnt, rank: '0};
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state    = S_IDLE;
                    n_emit_clr = 1'b0;
                    if (r_emit_clr) begin
                        n_done   = 1'b1;
                        n_result = '{status: ST_CLEARED, total_cost: '0,
                                     tree_edges: '0};
                    end
                end
            end
            S_FA, S_FB: begin
                // climb until the entry points at itself
                if (r_q.parent == r_cur) begin
                    rd_en = 1'b1;
                    if (r_state == S_FA) begin
                        n_ra     = r_cur;
                        n_rank_a = r_q.rank;
                        n_cur    = r_a;
                        rd_addr  = r_a;
                        n_state  = S_CA;
                    end else begin
                        n_rb     = r_cur;
                        n_rank_b = r_q.rank;
                        n_cur    = r_b;
                        rd_addr  = r_b;
                        n_state  = S_CB;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_q.parent;
                    n_cur   = r_q.parent;
                end
            end
            S_CA: begin
                // second walk: point every node on the path at the root
                if (r_cur == r_ra) begin
                    rd_en   = 1'b1;
                    rd_addr = r_b;
                    n_cur   = r_b;
                    n_state = S_FB;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_cur;
                    wr_data = '{parent: r_ra, rank: r_q.rank};
                    rd_en   = 1'b1;
                    rd_addr = r_q.parent;
                    n_cur   = r_q.parent;
                end
            end
            S_CB: begin
                if (r_cur == r_rb) begin
                    n_done = 1'b1;
                    if (r_ra == r_rb) begin
                        n_state  = S_IDLE;
                        n_result = '{status: ST_SAME_SET, total_cost: r_cost,
                                     tree_edges: r_edges};
                    end else begin
                        n_cost   = cost_add[COST_W] ? COST_MAX
                                                    : cost_add[COST_W-1:0];
                        n_edges  = (r_edges == EDGES_MAX) ? r_edges
                                                          : r_edges + 1'b1;
                        n_result = '{status: ST_ACCEPTED, total_cost: n_cost,
                                     tree_edges: n_edges};
                        n_state  = S_LINK;
                    end
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_cur;
                    wr_data = '{parent: r_rb, rank: r_q.rank};
                    rd_en   = 1'b1;
                    rd_addr = r_q.parent;
                    n_cur   = r_q.parent;
                end
            end
            S_LINK: begin
                wr_en = 1'b1;
                if (r_rank_a > r_rank_b) begin
                    wr_addr = r_rb;
                    wr_data = '{parent: r_ra, rank: r_rank_b};
                    n_state = S_IDLE;
                end else begin
                    wr_addr = r_ra;
                    wr_data = '{parent: r_rb, rank: r_rank_a};
                    if (r_rank_a == r_rank_b && r_rank_b != RANK_MAX) begin
                        n_state = S_RANK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RANK: begin
                wr_en   = 1'b1;
                wr_addr = r_rb;
                wr_data = '{parent: r_rb, rank: r_rank_b + 1'b1};
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_q <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_cnt        <= '0;
            r_emit_clr   <= 1'b0;
            r_cost       <= '0;
            r_edges      <= '0;
            r_node_count <= NODE_COUNT_RST;
            r_done       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_emit_clr <= n_emit_clr;
            r_cost     <= n_cost;
            r_edges    <= n_edges;
            r_done     <= n_done;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_a      <= n_a;
        r_b      <= n_b;
        r_ra     <= n_ra;
        r_rb     <= n_rb;
        r_rank_a <= n_rank_a;
        r_rank_b <= n_rank_b;
        r_w      <= n_w;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: dv/tb_kruskal_union_find_edge_filter.sv
`timescale 1ns / 1ps

module tb_kruskal_union_find_edge_filter;
    import kuf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    // disjoint-set forest kept alongside the block, plus the totals it should report
    class kruskal_forest_model;
        int unsigned       parent_of_node [NODES];
        logic [RANK_W-1:0] rank_of_node [NODES];
        logic [COST_W-1:0] cost_total;
        logic [EDGE_W-1:0] edge_count;
        logic [CNT_W-1:0]  node_limit;
        t_result           pending_totals [$];
        int                mismatches;
        int                status_seen [4];

        function new();
            reset_forest();
            node_limit = NODE_COUNT_RST;
            mismatches = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void reset_forest();
            for (int i = 0; i < NODES; i++) begin
                parent_of_node[i] = i;
                rank_of_node[i]   = '0;
            end
            cost_total = '0;
            edge_count = '0;
        endfunction

        function int unsigned find_and_compress(int unsigned x);
            int unsigned root;
            int unsigned walk;
            int unsigned nxt;
            root = x;
            while (parent_of_node[root] != root) root = parent_of_node[root];
            walk = x;
            while (walk != root) begin
                nxt = parent_of_node[walk];
                parent_of_node[walk] = root;
                walk = nxt;
            end
            return root;
        endfunction

        function void take_word(t_item w);
            t_result           r;
            int unsigned       ra;
            int unsigned       rb;
            logic [COST_W:0]   sum;
            if (w.action == ACT_CLEAR) begin
                reset_forest();
                r.status = ST_CLEARED;
            end else if (w.node_a >= node_limit || w.node_b >= node_limit) begin
                r.status = ST_BAD_NODE;
            end else begin
                ra = find_and_compress(w.node_a);
                rb = find_and_compress(w.node_b);
                if (ra == rb) begin
                    r.status = ST_SAME_SET;
                end else begin
                    r.status = ST_ACCEPTED;
                    sum = cost_total + w.weight;
                    cost_total = (sum > COST_MAX) ? COST_MAX : sum[COST_W-1:0];
                    if (edge_count != EDGES_MAX) edge_count = edge_count + 1'b1;
                    // union by rank, ties hang a's root under b's root
                    if (rank_of_node[ra] > rank_of_node[rb]) begin
                        parent_of_node[rb] = ra;
                    end else begin
                        parent_of_node[ra] = rb;
                        if (rank_of_node[ra] == rank_of_node[rb] && rank_of_node[rb] != RANK_MAX)
                            rank_of_node[rb] = rank_of_node[rb] + 1'b1;
                    end
                end
            end
            r.total_cost = cost_total;
            r.tree_edges = edge_count;
            status_seen[r.status]++;
            pending_totals.push_back(r);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 100) $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending_totals.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d cost=%0d edges=%0d",
                                          got.status, got.total_cost, got.tree_edges));
                return;
            end
            want = pending_totals.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.total_cost !== want.total_cost)
                report_mismatch($sformatf("total_cost got %0d want %0d",
                                          got.total_cost, want.total_cost));
            if (got.tree_edges !== want.tree_edges)
                report_mismatch($sformatf("tree_edges got %0d want %0d",
                                          got.tree_edges, want.tree_edges));
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_item             i_item;
    logic              i_cfg_we;
    logic [CNT_W-1:0]  i_cfg_data;
    logic              o_done;
    t_result           o_result;

    kruskal_forest_model forest;
    int                  idle_cycles = 0;
    bit                  gaps_on = 1'b1;

    always #4 i_clk = ~i_clk;

    kruskal_union_find_edge_filter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) forest.check_result(o_result);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_item edge_word(int a, int b, int w);
        t_item t;
        t.action = ACT_EDGE;
        t.node_a = a[NODE_W-1:0];
        t.node_b = b[NODE_W-1:0];
        t.weight = w[W_W-1:0];
        return t;
    endfunction

    function automatic t_item clear_word();
        t_item t;
        t.action = ACT_CLEAR;
        t.node_a = NODE_W'($urandom);
        t.node_b = NODE_W'($urandom);
        t.weight = W_W'($urandom);
        return t;
    endfunction

    function automatic int pick_node(int limit, int span, int base);
        if (limit == 0) return $urandom_range(0, NODES - 1);
        return (base + $urandom_range(0, span - 1)) % ((limit < NODES) ? limit : NODES);
    endfunction

    // called on a falling edge; returns on a falling edge, start still high only with no gap
    task automatic send_word(input t_item w);
        int gap;
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy !== 1'b0);
        forest.take_word(w);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (forest.pending_totals.size() != 0 || busy !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic write_node_count(input logic [CNT_W-1:0] v);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        forest.node_limit = v;
    endtask

    task automatic run_directed();
        send_word(edge_word(0, 1, 0));
        send_word(edge_word(1023, 1022, 65535));
        send_word(edge_word(5, 5, 7));          // self loop
        send_word(edge_word(1, 0, 3));          // already joined
        send_word(edge_word(0, 1023, 65535));
        send_word(edge_word(1, 1022, 100));
        // grow a rank-3 tree, then hang the first set onto it
        send_word(edge_word(2, 3, 10));
        send_word(edge_word(4, 5, 10));
        send_word(edge_word(2, 4, 11));
        send_word(edge_word(6, 7, 12));
        send_word(edge_word(8, 9, 12));
        send_word(edge_word(6, 8, 12));
        send_word(edge_word(2, 6, 13));
        send_word(edge_word(3, 0, 20));
        send_word(edge_word(9, 1023, 21));
        // shrink the node range, forest stays
        write_node_count(5);
        send_word(edge_word(4, 5, 1));
        send_word(edge_word(5, 4, 1));
        send_word(edge_word(3, 4, 1));
        send_word(edge_word(1023, 0, 1));
        send_word(clear_word());
        write_node_count(0);
        send_word(edge_word(0, 0, 2));
        write_node_count(1);
        send_word(edge_word(0, 0, 1));
        send_word(edge_word(0, 1, 1));
    endtask

    task automatic run_random();
        int limits [10];
        int span_opts [4];
        int limit;
        int n_items;
        int span;
        int base;
        int cur_w;
        int a;
        int b;
        int r;
        limits    = '{1024, 2047, 1023, 300, 37, 2, 1, 0, 0, 1024};
        limits[8] = $urandom_range(1, 1024);
        span_opts = '{4, 16, 64, 1024};
        for (int ph = 0; ph < 10; ph++) begin
            limit = limits[ph];
            write_node_count(limit[CNT_W-1:0]);
            gaps_on = (ph % 3 != 2);
            cur_w   = $urandom_range(0, 200);
            if ($urandom_range(0, 1) == 0) send_word(clear_word());
            n_items = (limit <= 1) ? 30 : 110;
            span    = span_opts[$urandom_range(0, 3)];
            base    = $urandom_range(0, NODES - 1);
            for (int k = 0; k < n_items; k++) begin
                if ($urandom_range(0, 19) == 0) begin
                    span = span_opts[$urandom_range(0, 3)];
                    base = $urandom_range(0, NODES - 1);
                end
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    send_word(clear_word());
                    cur_w = $urandom_range(0, 200);
                end else if (r < 8) begin
                    send_word(edge_word($urandom_range(0, NODES - 1),
                                        $urandom_range(0, NODES - 1),
                                        $urandom_range(0, 65535)));
                end else begin
                    a = pick_node(limit, span, base);
                    b = pick_node(limit, span, base);
                    // endpoint right at the node range limit
                    if (r < 12 && limit < NODES) a = limit;
                    if ($urandom_range(0, 19) == 0) begin
                        send_word(edge_word(a, b, $urandom_range(0, 65535)));
                    end else begin
                        send_word(edge_word(a, b, cur_w));
                        cur_w = cur_w + $urandom_range(0, 400);
                        if (cur_w > 65535) cur_w = 65535;
                    end
                end
            end
        end
    endtask

    initial begin
        forest     = new();
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random();
        settle();
        repeat (8) @(posedge i_clk);
        $display("edge filter run: %0d accepted, %0d same-set, %0d bad index, %0d clears",
                 forest.status_seen[ST_ACCEPTED], forest.status_seen[ST_SAME_SET],
                 forest.status_seen[ST_BAD_NODE], forest.status_seen[ST_CLEARED]);
        $display("node_count swept from 0 to 2047 with shrinks over live forests, %0d mismatches",
                 forest.mismatches);
        if (forest.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/kuf_pkg.sv
design/kruskal_union_find_edge_filter.sv
dv/tb_kruskal_union_find_edge_filter.sv
